// ===== rtl/core/per_sensor_moving_average_alarm_defines.svh =====
// Assertion macros for the per-sensor moving average alarm.
// No dependencies; included by the port checker.
`ifndef PER_SENSOR_MOVING_AVERAGE_ALARM_DEFINES_SVH
`define PER_SENSOR_MOVING_AVERAGE_ALARM_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PSMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PSMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/psma_pkg.sv =====
// Shared types and constants for the per-sensor moving average alarm.
// No dependencies.
package psma_pkg;

    localparam int ID_W       = 16;
    localparam int SAMPLE_W   = 16;
    localparam int HELD_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // widest per-entry fields over the legal parameter range
    localparam int IDXW_MAX  = 8;
    localparam int POSW_MAX  = 4;
    localparam int FILLW_MAX = 5;
    localparam int SUMW_MAX  = 20;

    localparam logic CMD_MAP  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] MAX_TEMP_RST = 16'sd3000;
    localparam logic signed [SAMPLE_W-1:0] MIN_TEMP_RST = 16'sd1000;

    typedef enum logic [3:0] {
        ST_MAPPED   = 4'd0,
        ST_DUP      = 4'd1,
        ST_FULL     = 4'd2,
        ST_UNKNOWN  = 4'd3,
        ST_FILLING  = 4'd4,
        ST_NORMAL   = 4'd5,
        ST_TOO_HOT  = 4'd6,
        ST_TOO_COLD = 4'd7,
        ST_END      = 4'd8
    } t_status;

    typedef struct packed {
        logic                       cmd;
        logic [ID_W-1:0]            sensor;
        logic [ID_W-1:0]            room;
        logic signed [SAMPLE_W-1:0] sample_value;
    } t_in_word;

    typedef struct packed {
        t_status                    status;
        logic [ID_W-1:0]            out_sensor;
        logic [ID_W-1:0]            out_room;
        logic signed [SAMPLE_W-1:0] average;
        logic [HELD_W-1:0]          samples_held;
    } t_out_word;

    // lookup token that travels down the cell row
    typedef struct packed {
        logic                       vld;
        logic                       found;
        logic [IDXW_MAX-1:0]        idx;
        logic [ID_W-1:0]            room;
        logic [POSW_MAX-1:0]        pos;
        logic [FILLW_MAX-1:0]       fill;
        logic signed [SUMW_MAX-1:0] sum;
    } t_token;

    // write command broadcast to all cells
    typedef struct packed {
        logic                       map;
        logic                       upd;
        logic [IDXW_MAX-1:0]        idx;
        logic [ID_W-1:0]            id;
        logic [ID_W-1:0]            room;
        logic [POSW_MAX-1:0]        pos;
        logic [FILLW_MAX-1:0]       fill;
        logic signed [SUMW_MAX-1:0] sum;
    } t_cell_wr;

endpackage

// ===== rtl/core/psma_cell.sv =====
// One table entry: sensor id, room, ring pointer, fill count and window sum.
// Passes the lookup token to its neighbor each cycle. Depends on psma_pkg.
module psma_cell #(
    parameter int IDX    = 0,
    parameter int POS_W  = 3,
    parameter int FILL_W = 3,
    parameter int SUM_W  = 19
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [psma_pkg::ID_W-1:0]     i_query_id,
    input  psma_pkg::t_token              i_token,
    input  psma_pkg::t_cell_wr            i_wr,
    output psma_pkg::t_token              o_token
);

    logic                         r_valid;
    logic [psma_pkg::ID_W-1:0]    r_id;
    logic [psma_pkg::ID_W-1:0]    r_room;
    logic [POS_W-1:0]             r_pos;
    logic [FILL_W-1:0]            r_fill;
    logic signed [SUM_W-1:0]      r_sum;
    psma_pkg::t_token             r_token;
    psma_pkg::t_token             n_token;
    logic                         sel;
    logic                         hit;

    assign sel = (i_wr.idx == psma_pkg::IDXW_MAX'(IDX));
    assign hit = i_token.vld && !i_token.found && r_valid && (r_id == i_query_id);

    always_comb begin
        n_token = i_token;
        if (hit) begin
            n_token.found = 1'b1;
            n_token.idx   = psma_pkg::IDXW_MAX'(IDX);
            n_token.room  = r_room;
            n_token.pos   = psma_pkg::POSW_MAX'(r_pos);
            n_token.fill  = psma_pkg::FILLW_MAX'(r_fill);
            n_token.sum   = psma_pkg::SUMW_MAX'(r_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_id    <= '0;
            r_pos   <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_token <= '0;
        end else begin
            r_token <= n_token;
            if (sel && i_wr.map) begin
                r_valid <= 1'b1;
                r_id    <= i_wr.id;
                r_pos   <= '0;
                r_fill  <= '0;
                r_sum   <= '0;
            end else if (sel && i_wr.upd) begin
                r_pos  <= i_wr.pos[POS_W-1:0];
                r_fill <= i_wr.fill[FILL_W-1:0];
                r_sum  <= i_wr.sum[SUM_W-1:0];
            end
        end
    end

    // room has no reset value; it is only read once mapped
    always_ff @(posedge i_clk) begin
        if (sel && i_wr.map) begin
            r_room <= i_wr.room;
        end
    end

    assign o_token = r_token;

endmodule

// ===== rtl/core/psma_ring.sv =====
// Sample ring storage for all entries, one write and one registered read port.
// Depends on psma_pkg.
module psma_ring #(
    parameter int ADDR_W = 7
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [ADDR_W-1:0]             i_wr_addr,
    input  logic [psma_pkg::SAMPLE_W-1:0] i_wr_data,
    input  logic                          i_rd_en,
    input  logic [ADDR_W-1:0]             i_rd_addr,
    output logic [psma_pkg::SAMPLE_W-1:0] o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [psma_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [psma_pkg::SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/psma_avg.sv =====
// Window average: signed sum divided by WINDOW, truncated toward zero.
// Reciprocal multiply with a registered product. Depends on psma_pkg.
module psma_avg #(
    parameter int WINDOW = 5,
    parameter int SUM_W  = 19
) (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic signed [SUM_W-1:0]              i_sum,
    output logic signed [psma_pkg::SAMPLE_W-1:0] o_avg
);

    // exact for every magnitude below 2**SUM_W
    localparam int SHIFT  = SUM_W + $clog2(WINDOW);
    localparam int MULT_W = SHIFT + 1;
    localparam int PROD_W = SUM_W + MULT_W;
    localparam longint MULT = ((longint'(1) << SHIFT) + longint'(WINDOW) - 1)
                              / longint'(WINDOW);

    logic [SUM_W-1:0]              mag;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W-1:0]             r_prod;
    logic                          r_neg;
    logic [psma_pkg::SAMPLE_W-1:0] quot;

    assign mag  = i_sum[SUM_W-1] ? (~i_sum + 1'b1) : i_sum;
    assign prod = PROD_W'(mag) * PROD_W'(MULT);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= prod;
            r_neg  <= i_sum[SUM_W-1];
        end
    end

    assign quot  = r_prod[SHIFT +: psma_pkg::SAMPLE_W];
    assign o_avg = r_neg ? $signed(-quot) : $signed(quot);

endmodule

// ===== rtl/core/per_sensor_moving_average_alarm.sv =====
// Top level of the per-sensor moving average alarm.
// Depends on psma_pkg, psma_cell, psma_ring and psma_avg.
//
// Usage:
//   Command word i_item is taken at a rising edge with start high and busy low.
//   Every command gives exactly one result word on o_result, valid for one
//   cycle while o_result_strobe is high. The receiver cannot stall; results
//   must be taken as they come.
//   Thresholds max_temp / min_temp are written on i_cfg_we / i_cfg_index /
//   i_cfg_data while the block is idle; there is no read-back.
// Sequence (N = MAX_SENSORS):
//   end-of-stream reading : busy stays low (next command may follow right away)
//   map command           : busy until the result edge
//   sensor reading        : busy until the result edge
//   The token walks the N cells one per cycle; the next edge decides a map,
//   or reads the ring for a reading, which adds the sum update, the multiply
//   and the result edge. Each result word is strobed on o_result for one cycle.
// Reset (synchronous, active low): table empty, all cells cleared, thresholds
//   back to 3000 and 1000. No clearing pass is needed: ring entries are read
//   only after they were written.
module per_sensor_moving_average_alarm #(
    parameter int MAX_SENSORS = 16,
    parameter int WINDOW      = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  psma_pkg::t_in_word                i_item,
    input  logic                              i_cfg_we,
    input  logic [psma_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [psma_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output psma_pkg::t_out_word               o_result,
    output logic                              o_result_strobe
);

    localparam int IDX_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int SUM_W   = psma_pkg::SAMPLE_W + $clog2(WINDOW);
    localparam int USED_W  = $clog2(MAX_SENSORS + 1);
    localparam int RING_AW = IDX_W + POS_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_READ = 5'b00100,
        S_MUL  = 5'b01000,
        S_AVG  = 5'b10000
    } t_state;

    t_state                                r_state,  n_state;
    psma_pkg::t_in_word                    r_item,   n_item;
    logic                                  r_launch, n_launch;
    psma_pkg::t_token                      r_hit,    n_hit;
    logic [USED_W-1:0]                     r_used,   n_used;
    logic signed [psma_pkg::SAMPLE_W-1:0]  r_max_temp, n_max_temp;
    logic signed [psma_pkg::SAMPLE_W-1:0]  r_min_temp, n_min_temp;
    logic signed [SUM_W-1:0]               r_sum_new, n_sum_new;
    logic [FILL_W-1:0]                     r_fill_new, n_fill_new;
    psma_pkg::t_out_word                   r_result, n_result;
    logic                                  r_strobe, n_strobe;

    // cell row
    psma_pkg::t_token   tok [MAX_SENSORS+1];
    psma_pkg::t_token   tail;
    psma_pkg::t_cell_wr cell_wr;

    // ring port
    logic                          ring_rd_en;
    logic                          ring_wr_en;
    logic [RING_AW-1:0]            ring_rd_addr;
    logic [RING_AW-1:0]            ring_wr_addr;
    logic [psma_pkg::SAMPLE_W-1:0] ring_rd_data;

    // datapath helpers
    logic [POS_W-1:0]              cur_pos;
    logic [POS_W-1:0]              next_pos;
    logic [FILL_W-1:0]             cur_fill;
    logic signed [SUM_W-1:0]       cur_sum;
    logic signed [SUM_W-1:0]       sample_ext;
    logic signed [SUM_W-1:0]       oldest_ext;
    logic signed [SUM_W-1:0]       thr_hi;
    logic signed [SUM_W-1:0]       thr_lo;
    logic                          win_full;
    logic                          avg_load;
    logic signed [psma_pkg::SAMPLE_W-1:0] avg_q;

    assign busy = (r_state != S_IDLE);

    // lookup token enters cell 0 in the cycle after the command is taken
    always_comb begin
        tok[0]     = '0;
        tok[0].vld = r_launch;
    end

    for (genvar g = 0; g < MAX_SENSORS; g++) begin : g_cell
        psma_cell #(
            .IDX    (g),
            .POS_W  (POS_W),
            .FILL_W (FILL_W),
            .SUM_W  (SUM_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_query_id (r_item.sensor),
            .i_token    (tok[g]),
            .i_wr       (cell_wr),
            .o_token    (tok[g+1])
        );
    end

    assign tail = tok[MAX_SENSORS];

    psma_ring #(
        .ADDR_W (RING_AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ring_wr_en),
        .i_wr_addr (ring_wr_addr),
        .i_wr_data (r_item.sample_value),
        .i_rd_en   (ring_rd_en),
        .i_rd_addr (ring_rd_addr),
        .o_rd_data (ring_rd_data)
    );

    psma_avg #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_avg (
        .i_clk  (i_clk),
        .i_load (avg_load),
        .i_sum  (r_sum_new),
        .o_avg  (avg_q)
    );

    // hit entry fields, cut back to their real widths
    assign cur_pos    = r_hit.pos[POS_W-1:0];
    assign cur_fill   = r_hit.fill[FILL_W-1:0];
    assign cur_sum    = $signed(r_hit.sum[SUM_W-1:0]);
    assign next_pos   = (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
    assign sample_ext = SUM_W'(r_item.sample_value);
    assign oldest_ext = SUM_W'($signed(ring_rd_data));

    assign ring_rd_addr = {tail.idx[IDX_W-1:0], tail.pos[POS_W-1:0]};
    assign ring_wr_addr = {r_hit.idx[IDX_W-1:0], cur_pos};

    // alarm limits scaled to sum units
    assign thr_hi   = SUM_W'(r_max_temp * WINDOW);
    assign thr_lo   = SUM_W'(r_min_temp * WINDOW);
    assign win_full = (r_fill_new == FILL_W'(WINDOW));

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_launch   = 1'b0;
        n_hit      = r_hit;
        n_used     = r_used;
        n_max_temp = r_max_temp;
        n_min_temp = r_min_temp;
        n_sum_new  = r_sum_new;
        n_fill_new = r_fill_new;
        n_result   = r_result;
        n_strobe   = 1'b0;
        cell_wr    = '0;
        ring_rd_en = 1'b0;
        ring_wr_en = 1'b0;
        avg_load   = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                psma_pkg::CFG_MAX_TEMP: n_max_temp = $signed(i_cfg_data);
                psma_pkg::CFG_MIN_TEMP: n_min_temp = $signed(i_cfg_data);
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    if (i_item.cmd == psma_pkg::CMD_READ && i_item.sensor == '0) begin
                        // end of stream: answered at once, table untouched
                        n_result        = '0;
                        n_result.status = psma_pkg::ST_END;
                        n_strobe        = 1'b1;
                    end else begin
                        n_launch = 1'b1;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (tail.vld) begin
                    n_hit                = tail;
                    n_result             = '0;
                    n_result.out_sensor  = r_item.sensor;
                    if (r_item.cmd == psma_pkg::CMD_MAP) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                        if (tail.found) begin
                            n_result.status       = psma_pkg::ST_DUP;
                            n_result.out_room     = tail.room;
                            n_result.samples_held = psma_pkg::HELD_W'(tail.fill);
                        end else if (r_used >= USED_W'(MAX_SENSORS)) begin
                            n_result.status = psma_pkg::ST_FULL;
                        end else begin
                            cell_wr.map       = 1'b1;
                            cell_wr.idx       = psma_pkg::IDXW_MAX'(r_used[IDX_W-1:0]);
                            cell_wr.id        = r_item.sensor;
                            cell_wr.room      = r_item.room;
                            n_used            = r_used + 1'b1;
                            n_result.status   = psma_pkg::ST_MAPPED;
                            n_result.out_room = r_item.room;
                        end
                    end else if (!tail.found) begin
                        n_result.status = psma_pkg::ST_UNKNOWN;
                        n_strobe        = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        // fetch the oldest sample; ignored while filling
                        ring_rd_en = 1'b1;
                        n_state    = S_READ;
                    end
                end
            end
            S_READ: begin
                if (cur_fill < FILL_W'(WINDOW)) begin
                    n_sum_new  = cur_sum + sample_ext;
                    n_fill_new = cur_fill + 1'b1;
                end else begin
                    n_sum_new  = cur_sum - oldest_ext + sample_ext;
                    n_fill_new = cur_fill;
                end
                ring_wr_en   = 1'b1;
                cell_wr.upd  = 1'b1;
                cell_wr.idx  = r_hit.idx;
                cell_wr.pos  = psma_pkg::POSW_MAX'(next_pos);
                cell_wr.fill = psma_pkg::FILLW_MAX'(n_fill_new);
                cell_wr.sum  = psma_pkg::SUMW_MAX'(n_sum_new);
                n_state      = S_MUL;
            end
            S_MUL: begin
                avg_load = 1'b1;
                n_state  = S_AVG;
            end
            S_AVG: begin
                n_result.out_room     = r_hit.room;
                n_result.samples_held = psma_pkg::HELD_W'(r_fill_new);
                n_result.average      = '0;
                if (!win_full) begin
                    n_result.status = psma_pkg::ST_FILLING;
                end else begin
                    n_result.average = avg_q;
                    if (r_sum_new > thr_hi) begin
                        n_result.status = psma_pkg::ST_TOO_HOT;
                    end else if (r_sum_new < thr_lo) begin
                        n_result.status = psma_pkg::ST_TOO_COLD;
                    end else begin
                        n_result.status = psma_pkg::ST_NORMAL;
                    end
                end
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launch   <= 1'b0;
            r_used     <= '0;
            r_max_temp <= psma_pkg::MAX_TEMP_RST;
            r_min_temp <= psma_pkg::MIN_TEMP_RST;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launch   <= n_launch;
            r_used     <= n_used;
            r_max_temp <= n_max_temp;
            r_min_temp <= n_min_temp;
            r_strobe   <= n_strobe;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_hit      <= n_hit;
        r_sum_new  <= n_sum_new;
        r_fill_new <= n_fill_new;
        r_result   <= n_result;
    end

    assign o_result        = r_result;
    assign o_result_strobe = r_strobe;

endmodule

// ===== rtl/core/psma_chk.sv =====
// Port-level checker for the per-sensor moving average alarm, bound to the top.
// Depends on psma_pkg and per_sensor_moving_average_alarm_defines.svh.
`include "per_sensor_moving_average_alarm_defines.svh"

module psma_chk #(
    parameter int WINDOW = 5
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input psma_pkg::t_in_word  i_item,
    input psma_pkg::t_out_word o_result,
    input logic                o_result_strobe
);

    // a table command raises busy once it is taken
    `PSMA_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, start && !busy && !(i_item.cmd && i_item.sensor == 16'd0), busy, "table command did not raise busy")

    // end of stream is answered in the very next cycle
    `PSMA_ASSERT_NEXT(a_end_next, i_clk, i_rst_n, start && !busy && i_item.cmd && i_item.sensor == 16'd0, o_result_strobe && o_result.status == psma_pkg::ST_END, "end mark not answered")

    // results only leave once the command is finished
    `PSMA_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_result_strobe, !busy, "result while busy")

    // an alarm verdict needs a full window
    `PSMA_ASSERT_NOW(a_verdict_full, i_clk, i_rst_n, o_result_strobe && (o_result.status == psma_pkg::ST_NORMAL || o_result.status == psma_pkg::ST_TOO_HOT || o_result.status == psma_pkg::ST_TOO_COLD), o_result.samples_held == psma_pkg::HELD_W'(WINDOW), "verdict before window full")

endmodule

bind per_sensor_moving_average_alarm psma_chk #(
    .WINDOW (WINDOW)
) u_psma_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_item          (i_item),
    .o_result        (o_result),
    .o_result_strobe (o_result_strobe)
);
